>>> rtl/campp_pkg.sv
// ----------------------------------------------------------------------------
// campp_pkg
// Shared types and constants of the camera point projection pipeline.
// ----------------------------------------------------------------------------
package campp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROT0  = 3'd0,
    CFG_ROT1  = 3'd1,
    CFG_ROT2  = 3'd2,
    CFG_TRANS = 3'd3,
    CFG_FOCAL = 3'd4,
    CFG_K1    = 3'd5,
    CFG_K2    = 3'd6
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int WORLD_W    = 32;
  localparam int PIX_W      = 25;

  // quotient bits of the normalized coordinate
  localparam int DIV_BITS = 31;
  // number of register stages from input register to output register
  localparam int NUM_STG  = 49;
  // stage that takes the divider result
  localparam int DIV_LAST = 4 + DIV_BITS;

  localparam logic [30:0] XY_CAP   = 31'h7FFF_FFFF;
  localparam logic [43:0] TERM_CAP = 44'h800_0000_0000;
  localparam logic [40:0] FD_CAP   = 41'h100_0000_0000;
  localparam logic [23:0] OUT_CAP  = 24'hFF_FFFF;
  localparam logic [46:0] ONE_Q20  = 47'h10_0000;
  localparam logic [23:0] FOCAL_RST = 24'd256;

  // side data carried through the divider stages
  typedef struct packed {
    logic same_x;
    logic same_y;
    logic zero;
    logic sat_x;
    logic sat_y;
  } div_side_t;

  // side data carried through the distortion and scaling stages
  typedef struct packed {
    logic [30:0] ax;
    logic [30:0] ay;
    logic        xneg;
    logic        yneg;
    logic        zero;
    logic        sat;
  } prj_side_t;

endpackage

>>> rtl/camera_point_projection_top.sv
// ----------------------------------------------------------------------------
// camera_point_projection_top
// Pinhole projection of homogeneous world points with k1/k2 radial
// distortion, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel in_valid/in_ready carries one world point (Q16.16) per
//    transaction; output channel out_valid/out_ready carries pixel_u,
//    pixel_v (Q16.8) and status for every point, in order.
//  - pose, focal length and distortion are written through cfg_write,
//    cfg_index, cfg_data, one register per cycle, while the pipe is empty.
//  - throughput is one point per clock while out_ready is high; the
//    pipe depth is set by the 31-stage restoring divider
//    (one quotient bit per stage) plus transform and distortion stages.
//  - when out_ready is low the whole pipe holds; the input register still
//    takes a transaction if it is empty, so nothing is lost or repeated.
//  - rst is synchronous: all stage valid bits clear, config goes to its
//    reset values (identity-free zero pose, focal 1.0, no distortion).
//  - zero depth gives status 1 with zero pixels; any clamp gives status 2.
// ----------------------------------------------------------------------------
module camera_point_projection_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [campp_pkg::WORLD_W-1:0] world_x,
  input  logic signed [campp_pkg::WORLD_W-1:0] world_y,
  input  logic signed [campp_pkg::WORLD_W-1:0] world_z,
  input  logic signed [campp_pkg::WORLD_W-1:0] world_w,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [campp_pkg::PIX_W-1:0]   pixel_u,
  output logic signed [campp_pkg::PIX_W-1:0]   pixel_v,
  output logic [1:0]                          status,
  input  logic                                cfg_write,
  input  logic [campp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [campp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import campp_pkg::*;

  // configuration registers
  logic [53:0]        rot_row [3];
  logic [62:0]        trans_cfg;
  logic [23:0]        focal;
  logic signed [23:0] k1_cfg;
  logic signed [23:0] k2_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= '0;
      rot_row[1] <= '0;
      rot_row[2] <= '0;
      trans_cfg  <= '0;
      focal      <= FOCAL_RST;
      k1_cfg     <= '0;
      k2_cfg     <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROT0:  rot_row[0] <= cfg_data[53:0];
        CFG_ROT1:  rot_row[1] <= cfg_data[53:0];
        CFG_ROT2:  rot_row[2] <= cfg_data[53:0];
        CFG_TRANS: trans_cfg  <= cfg_data;
        CFG_FOCAL: focal      <= cfg_data[23:0];
        CFG_K1:    k1_cfg     <= cfg_data[23:0];
        CFG_K2:    k2_cfg     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // unpacked pose entries and coefficient magnitudes
  logic signed [17:0] rot_e [3][3];
  logic signed [20:0] tr_e  [3];
  logic [23:0]        k1m, k2m;
  logic               k1neg, k2neg;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rot_e[r][c] = rot_row[r][18*c +: 18];
      end
      tr_e[r] = trans_cfg[21*r +: 21];
    end
    k1neg = k1_cfg[23];
    k2neg = k2_cfg[23];
    k1m   = k1neg ? 24'(-k1_cfg) : k1_cfg;
    k2m   = k2neg ? 24'(-k2_cfg) : k2_cfg;
  end

  // pipeline control: stage valid bits, global advance, input collapse
  logic [NUM_STG-1:0] vld;
  logic               adv;
  logic               en0;

  assign adv       = !vld[NUM_STG-1] || out_ready;
  assign en0       = !vld[0] || adv;
  assign in_ready  = en0;
  assign out_valid = vld[NUM_STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en0) begin
        vld[0] <= in_valid;
      end
      if (adv) begin
        vld[NUM_STG-1:1] <= vld[NUM_STG-2:0];
      end
    end
  end

  // stage 0: input register
  logic signed [31:0] s0_w [4];

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_w[0] <= world_x;
      s0_w[1] <= world_y;
      s0_w[2] <= world_z;
      s0_w[3] <= world_w;
    end
  end

  // stages 1-4: pose products, camera coordinates, magnitudes, divider setup
  logic signed [49:0] s1_pr [3][3];
  logic signed [52:0] s1_pt [3];
  logic signed [63:0] s2_c  [3];
  logic [62:0]        s3_num [2];
  logic [62:0]        s3_den;
  logic [1:0]         s3_same;
  logic               s3_zero;

  // divider stage registers, index 0 is the setup stage
  logic [78:0] dv_rem  [2][DIV_BITS+1];
  logic [30:0] dv_q    [2][DIV_BITS+1];
  logic [62:0] dv_den  [DIV_BITS+1];
  div_side_t   dv_side [DIV_BITS+1];
  logic [93:0] dv_shd  [DIV_BITS];
  logic        dv_ge   [2][DIV_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_pr[r][c] <= rot_e[r][c] * s0_w[c];
        end
        s1_pt[r] <= tr_e[r] * s0_w[3];
        s2_c[r]  <= s1_pr[r][0] + s1_pr[r][1] + s1_pr[r][2] + (64'(s1_pt[r]) <<< 8);
      end
      for (int r = 0; r < 2; r++) begin
        s3_num[r]  <= s2_c[r][63] ? 63'(-s2_c[r]) : s2_c[r][62:0];
        s3_same[r] <= s2_c[r][63] == s2_c[2][63];
      end
      s3_den  <= s2_c[2][63] ? 63'(-s2_c[2]) : s2_c[2][62:0];
      s3_zero <= s2_c[2] == 64'sd0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      dv_shd[k] = 94'(dv_den[k]) << (DIV_BITS - 1 - k);
      for (int r = 0; r < 2; r++) begin
        dv_ge[r][k] = {15'd0, dv_rem[r][k]} >= dv_shd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // divider setup
      for (int r = 0; r < 2; r++) begin
        dv_rem[r][0] <= {s3_num[r], 16'd0};
        dv_q[r][0]   <= '0;
      end
      dv_den[0]         <= s3_den;
      dv_side[0].same_x <= s3_same[0];
      dv_side[0].same_y <= s3_same[1];
      dv_side[0].zero   <= s3_zero;
      // integer part of the ratio too large for Q15.16
      dv_side[0].sat_x  <= {15'd0, s3_num[0]} >= {s3_den, 15'd0};
      dv_side[0].sat_y  <= {15'd0, s3_num[1]} >= {s3_den, 15'd0};
      for (int k = 0; k < DIV_BITS; k++) begin
        for (int r = 0; r < 2; r++) begin
          dv_rem[r][k+1] <= dv_ge[r][k] ? dv_rem[r][k] - dv_shd[k][78:0] : dv_rem[r][k];
          dv_q[r][k+1]   <= {dv_q[r][k][29:0], dv_ge[r][k]};
        end
        dv_den[k+1]  <= dv_den[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // distortion and scaling stages
  prj_side_t ps [12];
  prj_side_t ps_sh [1:11];
  logic [30:0] q_ax, q_ay;
  div_side_t   q_sd;

  logic [61:0]        m_sq [2];
  logic [50:0]        m_r2;
  logic [63:0]        m_r4p;
  logic               m_r4hi;
  logic [49:0]        m_t1lo;
  logic [48:0]        m_t1hi;
  logic [43:0]        m_r4, m_t1, m_t1b, m_t1c, m_t2;
  logic [45:0]        m_t2lo, m_t2hi;
  logic signed [46:0] m_d;
  logic [45:0]        m_dm;
  logic               m_dneg [4];
  logic [46:0]        m_fdlo, m_fdhi;
  logic [40:0]        m_fd;
  logic [51:0]        m_plo [2];
  logic [50:0]        m_phi [2];

  // combinational helpers for the clamp stages
  logic [43:0]        c_r4s;
  logic [74:0]        c_t1f;
  logic [68:0]        c_t2f;
  logic [70:0]        c_fdf;
  logic [72:0]        c_pf [2];
  logic               c_r4sat, c_t1sat, c_t2sat, c_fdsat;
  logic [1:0]         c_psat;
  logic [23:0]        c_pm [2];
  logic signed [46:0] c_st1, c_st2;

  assign q_sd = dv_side[DIV_BITS];
  assign q_ax = q_sd.sat_x ? XY_CAP : dv_q[0][DIV_BITS];
  assign q_ay = q_sd.sat_y ? XY_CAP : dv_q[1][DIV_BITS];

  always_comb begin
    c_r4s   = m_r4p[63:20];
    c_r4sat = m_r4hi || (c_r4s > TERM_CAP);
    c_t1f   = {m_t1hi, 26'd0} + 75'(m_t1lo);
    c_t1sat = c_t1f[74:20] > 55'(TERM_CAP);
    c_t2f   = {1'b0, m_t2hi, 22'd0} + 69'(m_t2lo);
    c_t2sat = c_t2f[68:20] > 49'(TERM_CAP);
    c_st1   = k1neg ? -$signed(47'(m_t1c)) : $signed(47'(m_t1c));
    c_st2   = k2neg ? -$signed(47'(m_t2)) : $signed(47'(m_t2));
    c_fdf   = {m_fdhi, 23'd0} + 71'(m_fdlo);
    c_fdsat = c_fdf[70:20] > 51'(FD_CAP);
    for (int r = 0; r < 2; r++) begin
      c_pf[r]   = {m_phi[r], 21'd0} + 73'(m_plo[r]);
      c_psat[r] = c_pf[r][72:16] > 57'(OUT_CAP);
      c_pm[r]   = c_psat[r] ? OUT_CAP : c_pf[r][39:16];
    end
  end

  // side data shift, saturation flags merged at the clamp stages
  always_comb begin
    for (int j = 1; j < 12; j++) begin
      ps_sh[j] = ps[j-1];
    end
    ps_sh[4].sat  = ps[3].sat || c_r4sat || c_t1sat;
    ps_sh[6].sat  = ps[5].sat || c_t2sat;
    ps_sh[10].sat = ps[9].sat || c_fdsat;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // normalized coordinates and their signs
      ps[0].ax   <= q_ax;
      ps[0].ay   <= q_ay;
      ps[0].xneg <= (q_ax != '0) && q_sd.same_x;
      ps[0].yneg <= (q_ay != '0) && q_sd.same_y;
      ps[0].zero <= q_sd.zero;
      ps[0].sat  <= q_sd.sat_x || q_sd.sat_y;
      for (int j = 1; j < 12; j++) begin
        ps[j] <= ps_sh[j];
      end
      // squares and r2
      m_sq[0] <= ps[0].ax * ps[0].ax;
      m_sq[1] <= ps[0].ay * ps[0].ay;
      m_r2    <= 51'((63'(m_sq[0]) + 63'(m_sq[1])) >> 12);
      // r4 and k1*r2 partial products
      m_r4p  <= m_r2[31:0] * m_r2[31:0];
      m_r4hi <= m_r2[50:32] != '0;
      m_t1lo <= k1m * m_r2[25:0];
      m_t1hi <= k1m * m_r2[50:26];
      // clamp r4 and k1*r2
      m_r4      <= c_r4sat ? TERM_CAP : c_r4s;
      m_t1      <= c_t1sat ? TERM_CAP : c_t1f[63:20];
      // k2*r4 partial products
      m_t2lo <= k2m * m_r4[21:0];
      m_t2hi <= k2m * m_r4[43:22];
      m_t1b  <= m_t1;
      // clamp k2*r4
      m_t2      <= c_t2sat ? TERM_CAP : c_t2f[63:20];
      m_t1c     <= m_t1b;
      // distortion factor
      m_d <= $signed(ONE_Q20) + c_st1 + c_st2;
      // its magnitude
      m_dneg[0] <= m_d[46];
      m_dm      <= m_d[46] ? 46'(-m_d) : m_d[45:0];
      // focal length times factor
      m_fdlo    <= focal * m_dm[22:0];
      m_fdhi    <= focal * m_dm[45:23];
      m_dneg[1] <= m_dneg[0];
      m_fd       <= c_fdsat ? FD_CAP : c_fdf[60:20];
      m_dneg[2]  <= m_dneg[1];
      // pixel partial products
      m_plo[0]  <= m_fd[20:0] * ps[10].ax;
      m_phi[0]  <= m_fd[40:21] * ps[10].ax;
      m_plo[1]  <= m_fd[20:0] * ps[10].ay;
      m_phi[1]  <= m_fd[40:21] * ps[10].ay;
      m_dneg[3] <= m_dneg[2];
      // output register
      if (ps[11].zero) begin
        pixel_u <= '0;
        pixel_v <= '0;
        status  <= ST_ZERO;
      end else begin
        pixel_u <= (m_dneg[3] != ps[11].xneg) ? -$signed({1'b0, c_pm[0]})
                                              : $signed({1'b0, c_pm[0]});
        pixel_v <= (m_dneg[3] != ps[11].yneg) ? -$signed({1'b0, c_pm[1]})
                                              : $signed({1'b0, c_pm[1]});
        status  <= (ps[11].sat || c_psat[0] || c_psat[1]) ? ST_SAT : ST_OK;
      end
    end
  end

  // zero depth never carries pixel values
  a_zero_px: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZERO |-> pixel_u == '0 && pixel_v == '0)
    else $error("zero-depth result with nonzero pixels");

  // an unsaturated result stays inside the symmetric range
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> pixel_u != 25'h100_0000 && pixel_v != 25'h100_0000)
    else $error("unsaturated result outside range");

  // an accepted transaction lands in the input register
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction lost at input register");

  // a stalled result is not dropped by the pipe
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_STG-1] && !out_ready |=> vld[NUM_STG-1])
    else $error("stalled result dropped");

  // while the pipe is stalled, every stage after the input register holds
  a_div_move: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld[NUM_STG-1:1]))
    else $error("pipe moved while stalled");

endmodule

>>> sim/tb_camera_point_projection_top.sv
// ----------------------------------------------------------------------------
// tb_camera_point_projection_top
// Self-checking bench for the camera point projection pipeline. A directed
// table runs first, under the reset pose and then under a known pose. Random
// points follow under several poses, lens settings and flow-control
// patterns. Results are compared in order: zero depth under the reset pose,
// else a bit-exact projection predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_camera_point_projection_top;
  import campp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = NUM_STG + 12;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_POINTS   = 230;

  typedef struct packed {
    logic signed [PIX_W-1:0] u;
    logic signed [PIX_W-1:0] v;
    status_t                 st;
  } pixel_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } point_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [WORLD_W-1:0] world_x, world_y, world_z, world_w;
  logic signed [PIX_W-1:0] pixel_u, pixel_v;
  logic [1:0] status;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the camera setup
  logic [53:0] pose_rot [3];
  logic [62:0] pose_trans;
  logic [23:0] lens_focal;
  logic signed [23:0] lens_k1, lens_k2;

  pixel_t pending_pixels [$];
  int errors = 0;
  int points_sent = 0;
  int pixels_seen = 0;
  int zero_depth_seen = 0;
  int saturated_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  camera_point_projection_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .world_x(world_x), .world_y(world_y), .world_z(world_z), .world_w(world_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_u(pixel_u), .pixel_v(pixel_v), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // (a*b) >> sh on magnitudes, clamped to cap
  function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                     int sh, longint unsigned cap,
                                                     inout bit sat);
    longint unsigned p;
    if (a == 0 || b == 0) return 0;
    if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) begin
      sat = 1'b1;
      return cap;
    end
    p = (a * b) >> sh;
    if (p > cap) begin
      sat = 1'b1;
      return cap;
    end
    return p;
  endfunction

  // |num| * 2^16 / |den| truncated, clamped just under 2^15
  function automatic longint unsigned normalized(longint unsigned num, longint unsigned den,
                                                 inout bit sat);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (q > (64'h7FFF_FFFF >> 16)) begin
      sat = 1'b1;
      return 64'h7FFF_FFFF;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic pixel_t project_point(point_t p);
    longint wv [4];
    longint cam [3];
    longint unsigned ax, ay, mz, r2, r4, t1, t2, fd, um, vm;
    longint dv, uv, vv;
    bit sat, xneg, yneg, dneg;
    pixel_t res;
    sat = 1'b0;
    wv[0] = longint'($signed(p.x));
    wv[1] = longint'($signed(p.y));
    wv[2] = longint'($signed(p.z));
    wv[3] = longint'($signed(p.w));
    for (int r = 0; r < 3; r++) begin
      cam[r] = longint'($signed(pose_trans[21*r +: 21])) * wv[3] * 256;
      for (int c = 0; c < 3; c++)
        cam[r] += longint'($signed(pose_rot[r][18*c +: 18])) * wv[c];
    end
    if (cam[2] == 0) begin
      res.u = '0;
      res.v = '0;
      res.st = ST_ZERO;
      return res;
    end
    mz = magnitude(cam[2]);
    ax = normalized(magnitude(cam[0]), mz, sat);
    ay = normalized(magnitude(cam[1]), mz, sat);
    // x = -Xc/Zc is negative when Xc and Zc share a sign
    xneg = ax != 0 && ((cam[0] < 0) == (cam[2] < 0));
    yneg = ay != 0 && ((cam[1] < 0) == (cam[2] < 0));
    r2 = (ax * ax + ay * ay) >> 12;
    r4 = scaled_product(r2, r2, 20, 64'h800_0000_0000, sat);
    t1 = scaled_product(magnitude(longint'(lens_k1)), r2, 20, 64'h800_0000_0000, sat);
    t2 = scaled_product(magnitude(longint'(lens_k2)), r4, 20, 64'h800_0000_0000, sat);
    dv = longint'(64'h10_0000) + (lens_k1 < 0 ? -longint'(t1) : longint'(t1))
         + (lens_k2 < 0 ? -longint'(t2) : longint'(t2));
    dneg = dv < 0;
    fd = scaled_product(longint'(lens_focal), magnitude(dv), 20, 64'h100_0000_0000, sat);
    um = scaled_product(fd, ax, 16, 64'hFF_FFFF, sat);
    vm = scaled_product(fd, ay, 16, 64'hFF_FFFF, sat);
    uv = (dneg != xneg) ? -longint'(um) : longint'(um);
    vv = (dneg != yneg) ? -longint'(vm) : longint'(vm);
    res.u = uv[PIX_W-1:0];
    res.v = vv[PIX_W-1:0];
    res.st = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", pixels_seen, what, got, want);
    errors++;
  endtask

  // compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_u !== want.u) report_mismatch("pixel_u", pixel_u, want.u);
        if (pixel_v !== want.v) report_mismatch("pixel_v", pixel_v, want.v);
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (want.st == ST_ZERO) zero_depth_seen++;
        if (want.st == ST_SAT) saturated_seen++;
      end
      pixels_seen++;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[camera_point_projection_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers
  // one register write per cycle; caller drops cfg_write afterwards
  task automatic set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_ROT0:  pose_rot[0] = value[53:0];
      CFG_ROT1:  pose_rot[1] = value[53:0];
      CFG_ROT2:  pose_rot[2] = value[53:0];
      CFG_TRANS: pose_trans = value[62:0];
      CFG_FOCAL: lens_focal = value[23:0];
      CFG_K1:    lens_k1 = value[23:0];
      CFG_K2:    lens_k2 = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_camera(logic [53:0] r0, logic [53:0] r1, logic [53:0] r2,
                             logic [62:0] t, logic [23:0] f, logic [23:0] k1,
                             logic [23:0] k2);
    set_register(CFG_ROT0, r0);
    set_register(CFG_ROT1, r1);
    set_register(CFG_ROT2, r2);
    set_register(CFG_TRANS, t);
    set_register(CFG_FOCAL, f);
    set_register(CFG_K1, k1);
    set_register(CFG_K2, k2);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every expected pixel has arrived, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // present one point and wait for its transaction
  task automatic send_point(point_t p, bit typed, pixel_t typed_pixel);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    world_x <= p.x;
    world_y <= p.y;
    world_z <= p.z;
    world_w <= p.w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(typed ? typed_pixel : project_point(p));
    points_sent++;
  endtask

  function automatic logic [17:0] rot_entry(bit wide);
    return wide ? 18'($urandom) : 18'($urandom_range(131072) - 65536);
  endfunction

  function automatic logic [53:0] rot_row(bit wide);
    return {rot_entry(wide), rot_entry(wide), rot_entry(wide)};
  endfunction

  // mostly small-coordinate points, some raw noise, some all-zero points
  function automatic point_t random_point();
    point_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      p.x = $urandom_range(2621440) - 1310720;
      p.y = $urandom_range(2621440) - 1310720;
      p.z = $urandom_range(2621440) - 1310720;
      p.w = ($urandom_range(9) == 0) ? 32'($urandom_range(262144)) : 32'd65536;
    end else if (pick < 95) begin
      p = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      p = '0;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus
  point_t directed_points [] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0001_0000},
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'h000A_0001, 32'h0001_0000},
    '{32'h0000_0000, 32'h8000_0000, 32'h0009_FFFF, 32'h0001_0000},
    '{32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000},
    '{32'hFFFF_0000, 32'h0001_8000, 32'h0014_0000, 32'h0001_0000},
    '{32'h0003_0000, 32'hFFFD_0000, 32'h0005_0000, 32'h0001_0000},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000},
    '{32'h0064_0000, 32'h0064_0000, 32'h000B_0000, 32'h0001_0000},
    '{32'h1234_5678, 32'hEDCB_A987, 32'h5555_5555, 32'hAAAA_AAAA},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h0000_8000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h0000_0001}
  };

  initial begin
    pixel_t zero_pixel;
    pixel_t unused_pixel;
    zero_pixel = '{u: '0, v: '0, st: ST_ZERO};
    unused_pixel = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    world_x <= '0;
    world_y <= '0;
    world_z <= '0;
    world_w <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_ROT0;
    cfg_data <= '0;
    pose_rot[0] = '0;
    pose_rot[1] = '0;
    pose_rot[2] = '0;
    pose_trans = '0;
    lens_focal = FOCAL_RST;
    lens_k1 = '0;
    lens_k2 = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // reset pose is all zero, so every point has zero depth
    foreach (directed_points[i]) send_point(directed_points[i], 1'b1, zero_pixel);
    drain_pipe();

    // identity pose ten units back, focal 500, mild barrel distortion
    load_camera({18'd0, 18'd0, 18'd65536}, {18'd0, 18'd65536, 18'd0},
                {18'd65536, 18'd0, 18'd0},
                {21'h1F_F600, 21'd0, 21'd0}, 24'd128000, -24'sd52429, 24'sd10486);
    foreach (directed_points[i]) send_point(directed_points[i], 1'b0, unused_pixel);
    drain_pipe();

    // random phases under rotating camera setups and flow-control patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 5)
        0: load_camera(rot_row(0), rot_row(0), rot_row(0),
                       {21'($urandom_range(8192) - 4096), 21'($urandom_range(4096)),
                        21'($urandom_range(4096))},
                       24'($urandom_range(400000)), 24'($urandom_range(200000) - 100000),
                       24'($urandom_range(40000) - 20000));
        1: load_camera(54'({$urandom, $urandom}), 54'({$urandom, $urandom}),
                       54'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                       24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
        2: load_camera(rot_row(0), rot_row(0), rot_row(1), 63'($urandom),
                       24'h00_0000, 24'h80_0000, 24'h7F_FFFF);
        3: load_camera({18'h1_FFFF, 18'h2_0000, 18'h1_FFFF}, {18'h2_0000, 18'h1_FFFF,
                       18'h2_0000}, rot_row(1), 63'h7FFF_FFFF_FFFF_FFFF,
                       24'($urandom), 24'($urandom), 24'($urandom));
        default: load_camera(rot_row(1), rot_row(1), rot_row(1), 63'({$urandom, $urandom}),
                             24'($urandom_range(2000000)), 24'($urandom_range(2000) - 1000),
                             24'($urandom_range(2000) - 1000));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < PHASE_POINTS; n++) begin
        // one mid-phase pause until the pipe has emptied
        if (ph == 3 && n == PHASE_POINTS / 2) begin
          in_valid <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
        send_point(random_point(), 1'b0, unused_pixel);
      end
      drain_pipe();
    end

    $display("covered %0d points, %0d results (%0d zero depth, %0d saturated)",
             points_sent, pixels_seen, zero_depth_seen, saturated_seen);
    $display("%0d camera setups, flow control from none to heavy on both sides",
             NUM_PHASES + 2);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("[camera_point_projection_top] OK");
    end else begin
      $display("[camera_point_projection_top] ERROR");
    end
    $finish;
  end

endmodule
